@@ hw/rtl/pidc_pkg.sv @@
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared widths, register codes, reset values and the symmetric clamp used by
// the PID controller.
// ----------------------------------------------------------------------------
package pidc_pkg;

   localparam int IO_WIDTH        = 32;
   localparam int GAIN_WIDTH      = 25;
   localparam int LIMIT_WIDTH     = 31;
   localparam int INTEG_WIDTH     = 32;
   localparam int CAP_WIDTH       = 61;
   localparam int TERM_WIDTH      = 62;
   localparam int SUM_WIDTH       = 64;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [GAIN_WIDTH-1:0]  GAIN_P_RESET         = 25'd393216;
   localparam logic [GAIN_WIDTH-1:0]  GAIN_I_RESET         = 25'd0;
   localparam logic [GAIN_WIDTH-1:0]  GAIN_D_RESET         = 25'd19660800;
   localparam logic [LIMIT_WIDTH-1:0] INTEGRAL_LIMIT_RESET = 31'd0;
   localparam logic [LIMIT_WIDTH-1:0] OUTPUT_LIMIT_RESET   = 31'd4325376;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_GAIN_P         = 3'd0,
      CSR_GAIN_I         = 3'd1,
      CSR_GAIN_D         = 3'd2,
      CSR_INTEGRAL_LIMIT = 3'd3,
      CSR_OUTPUT_LIMIT   = 3'd4
   } csr_index_type;

   function automatic logic signed [INTEG_WIDTH-1:0] clamp_sym(
      input logic signed [SUM_WIDTH-1:0] value,
      input logic [LIMIT_WIDTH-1:0]      limit
   );
      logic signed [SUM_WIDTH-1:0] pos_lim;
      logic signed [SUM_WIDTH-1:0] neg_lim;
      logic signed [SUM_WIDTH-1:0] res;
      pos_lim = $signed(SUM_WIDTH'(limit));
      neg_lim = -pos_lim;
      if (value > pos_lim) begin
         res = pos_lim;
      end else if (value < neg_lim) begin
         res = neg_lim;
      end else begin
         res = value;
      end
      return res[INTEG_WIDTH-1:0];
   endfunction

endpackage

@@ hw/rtl/pidc_err_stage.sv @@
// ----------------------------------------------------------------------------
// pidc_err_stage
// Forms the saturated error and its difference to the previous error.
// ----------------------------------------------------------------------------
module pidc_err_stage #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic signed [pidc_pkg::IO_WIDTH-1:0] measured,
   input  logic signed [pidc_pkg::IO_WIDTH-1:0] target,
   input  logic signed [VALUE_WIDTH-1:0]        prev_error,
   output logic signed [VALUE_WIDTH-1:0]        error,
   output logic signed [VALUE_WIDTH:0]          delta
);

   localparam int DIFF_WIDTH = pidc_pkg::IO_WIDTH + 1;
   localparam int XW = ((VALUE_WIDTH > DIFF_WIDTH) ? VALUE_WIDTH : DIFF_WIDTH) + 1;
   localparam logic signed [XW-1:0] HI = {{(XW-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic signed [XW-1:0] LO = -HI - XW'(1);

   logic signed [XW-1:0] diff;

   always_comb begin
      diff = XW'(target) - XW'(measured);
      if (diff > HI) begin
         error = HI[VALUE_WIDTH-1:0];
      end else if (diff < LO) begin
         error = LO[VALUE_WIDTH-1:0];
      end else begin
         error = diff[VALUE_WIDTH-1:0];
      end
      delta = (VALUE_WIDTH+1)'(error) - (VALUE_WIDTH+1)'(prev_error);
   end

endmodule

@@ hw/rtl/pidc_scale.sv @@
// ----------------------------------------------------------------------------
// pidc_scale
// Gain multiply with fraction shift, magnitude truncated toward zero and capped.
// ----------------------------------------------------------------------------
module pidc_scale #(
   parameter int IN_WIDTH  = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic signed [IN_WIDTH-1:0]               value,
   input  logic [pidc_pkg::GAIN_WIDTH-1:0]          gain,
   output logic signed [pidc_pkg::TERM_WIDTH-1:0]   term
);

   localparam int PW    = IN_WIDTH + pidc_pkg::GAIN_WIDTH;
   localparam int EXT_W = (PW > pidc_pkg::TERM_WIDTH) ? PW : pidc_pkg::TERM_WIDTH;
   localparam logic [EXT_W-1:0] CAP = EXT_W'({pidc_pkg::CAP_WIDTH{1'b1}});

   logic                                neg;
   logic [IN_WIDTH-1:0]                 mag;
   logic [PW-1:0]                       prod;
   logic [EXT_W-1:0]                    shifted;
   logic [pidc_pkg::CAP_WIDTH-1:0]      capped;
   logic signed [pidc_pkg::TERM_WIDTH-1:0] pos_term;

   always_comb begin
      neg      = value[IN_WIDTH-1];
      mag      = neg ? IN_WIDTH'(-value) : IN_WIDTH'(value);
      prod     = PW'(mag) * PW'(gain);
      shifted  = EXT_W'(prod >> FRAC_BITS);
      capped   = (shifted > CAP) ? CAP[pidc_pkg::CAP_WIDTH-1:0]
                                 : shifted[pidc_pkg::CAP_WIDTH-1:0];
      pos_term = $signed(pidc_pkg::TERM_WIDTH'(capped));
      term     = neg ? -pos_term : pos_term;
   end

endmodule

@@ hw/rtl/pid_with_integral_and_output_clamp_unit.sv @@
// ----------------------------------------------------------------------------
// pid_with_integral_and_output_clamp_unit
// Positional PID controller with clamped integral and saturated output.
// A request passes the error, product and sum registers before rsp_valid rises.
// Throughput: one request per cycle while rsp_ready does not stall the pipeline;
// the integral loop closes in the last stage. Stages hold under rsp_ready
// backpressure and refill as soon as they drain. Reset clears the pipeline,
// the integral and the previous error, and loads the default gains and limits.
// ----------------------------------------------------------------------------
module pid_with_integral_and_output_clamp_unit #(
   parameter int VALUE_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_ready,
   input  logic signed [pidc_pkg::IO_WIDTH-1:0]       req_measured,
   input  logic signed [pidc_pkg::IO_WIDTH-1:0]       req_target,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic signed [pidc_pkg::IO_WIDTH-1:0]       rsp_drive,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [pidc_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [pidc_pkg::CSR_DATA_WIDTH-1:0]        csr_wdata
);

   localparam int GW = pidc_pkg::GAIN_WIDTH;
   localparam int LW = pidc_pkg::LIMIT_WIDTH;
   localparam int TW = pidc_pkg::TERM_WIDTH;
   localparam int SW = pidc_pkg::SUM_WIDTH;
   localparam int IW = pidc_pkg::INTEG_WIDTH;

   // configuration
   logic [GW-1:0] gain_p_ff, gain_p_in, gain_i_ff, gain_i_in, gain_d_ff, gain_d_in;
   logic [LW-1:0] ilim_ff, ilim_in, olim_ff, olim_in;

   // pipeline
   logic                          s1_valid_ff, s1_valid_in;
   logic signed [VALUE_WIDTH-1:0] s1_error_ff, s1_error_in;
   logic signed [VALUE_WIDTH:0]   s1_delta_ff, s1_delta_in;
   logic signed [VALUE_WIDTH-1:0] prev_error_ff, prev_error_in;
   logic                          s2_valid_ff, s2_valid_in;
   logic signed [TW-1:0]          p_term_ff, p_term_in, i_term_ff, i_term_in;
   logic signed [TW-1:0]          d_term_ff, d_term_in;
   logic signed [IW-1:0]          integral_ff, integral_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [IW-1:0]          drive_ff, drive_in;

   logic                          req_accept, s2_load, rsp_load;
   logic signed [VALUE_WIDTH-1:0] error;
   logic signed [VALUE_WIDTH:0]   delta;

   assign csr_ready = 1'b1;

   always_comb begin
      gain_p_in = gain_p_ff;
      gain_i_in = gain_i_ff;
      gain_d_in = gain_d_ff;
      ilim_in   = ilim_ff;
      olim_in   = olim_ff;
      if (csr_valid) begin
         unique case (csr_index)
            pidc_pkg::CSR_GAIN_P:         gain_p_in = csr_wdata[GW-1:0];
            pidc_pkg::CSR_GAIN_I:         gain_i_in = csr_wdata[GW-1:0];
            pidc_pkg::CSR_GAIN_D:         gain_d_in = csr_wdata[GW-1:0];
            pidc_pkg::CSR_INTEGRAL_LIMIT: ilim_in   = csr_wdata[LW-1:0];
            pidc_pkg::CSR_OUTPUT_LIMIT:   olim_in   = csr_wdata[LW-1:0];
            default: ;
         endcase
      end
   end

   pidc_err_stage #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_err (
      .measured  (req_measured),
      .target    (req_target),
      .prev_error(prev_error_ff),
      .error     (error),
      .delta     (delta)
   );

   pidc_scale #(.IN_WIDTH(VALUE_WIDTH), .FRAC_BITS(FRAC_BITS)) u_scale_p (
      .value(s1_error_ff), .gain(gain_p_ff), .term(p_term_in)
   );
   pidc_scale #(.IN_WIDTH(VALUE_WIDTH), .FRAC_BITS(FRAC_BITS)) u_scale_i (
      .value(s1_error_ff), .gain(gain_i_ff), .term(i_term_in)
   );
   pidc_scale #(.IN_WIDTH(VALUE_WIDTH + 1), .FRAC_BITS(FRAC_BITS)) u_scale_d (
      .value(s1_delta_ff), .gain(gain_d_ff), .term(d_term_in)
   );

   // flow control
   assign rsp_load   = s2_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign s2_load    = s1_valid_ff && (!s2_valid_ff || rsp_load);
   assign req_ready  = !s1_valid_ff || s2_load;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      s1_valid_in   = req_accept ? 1'b1 : (s2_load ? 1'b0 : s1_valid_ff);
      s1_error_in   = req_accept ? error : s1_error_ff;
      s1_delta_in   = req_accept ? delta : s1_delta_ff;
      prev_error_in = req_accept ? error : prev_error_ff;
      s2_valid_in   = s2_load ? 1'b1 : (rsp_load ? 1'b0 : s2_valid_ff);
      rsp_valid_in  = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      integral_in   = integral_ff;
      drive_in      = drive_ff;
      if (rsp_load) begin
         integral_in = pidc_pkg::clamp_sym(SW'(integral_ff) + SW'(i_term_ff), ilim_ff);
         drive_in    = pidc_pkg::clamp_sym(SW'(p_term_ff) + SW'(integral_in)
                                           + SW'(d_term_ff), olim_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff     <= pidc_pkg::GAIN_P_RESET;
         gain_i_ff     <= pidc_pkg::GAIN_I_RESET;
         gain_d_ff     <= pidc_pkg::GAIN_D_RESET;
         ilim_ff       <= pidc_pkg::INTEGRAL_LIMIT_RESET;
         olim_ff       <= pidc_pkg::OUTPUT_LIMIT_RESET;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         prev_error_ff <= '0;
         integral_ff   <= '0;
      end else begin
         gain_p_ff     <= gain_p_in;
         gain_i_ff     <= gain_i_in;
         gain_d_ff     <= gain_d_in;
         ilim_ff       <= ilim_in;
         olim_ff       <= olim_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         prev_error_ff <= prev_error_in;
         integral_ff   <= integral_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_error_ff <= s1_error_in;
      s1_delta_ff <= s1_delta_in;
      if (s2_load) begin
         p_term_ff <= p_term_in;
         i_term_ff <= i_term_in;
         d_term_ff <= d_term_in;
      end
      drive_ff <= drive_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = drive_ff;

   // output never leaves the configured limit
   a_drive_in_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (SW'(drive_ff) <= $signed(SW'(olim_ff)))
                    && (SW'(drive_ff) >= -$signed(SW'(olim_ff))))
      else $error("drive outside output limit");

   // a product stage blocked by the output register keeps its request
   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !rsp_load |=> s2_valid_ff && $stable(p_term_ff) && $stable(d_term_ff))
      else $error("product stage lost a request");

   // integral only moves when a result is produced
   a_integral_moves_on_load: assert property (@(posedge clock) disable iff (reset)
      !rsp_load |=> $stable(integral_ff))
      else $error("integral changed without a result");

   // reset leaves the loop empty with a cleared integral
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !s1_valid_ff && !s2_valid_ff && integral_ff == '0)
      else $error("state not cleared by reset");

endmodule
